>>> sv/msp_pkg.sv
// ============================================================================
// msp_pkg
// Shared constants and types for the serial request frame receiver.
// ============================================================================
`default_nettype none

package msp_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
    localparam int PADDR_W      = 3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_ARROW  = 8'h3C;
    localparam logic [7:0] CH_HASH   = 8'h23;

    localparam logic [7:0] REBOOT_CHAR_RESET = 8'd82;
    localparam logic [PADDR_W-1:0] REG_REBOOT_CHAR = PADDR_W'(0);

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_CONSOLE = 2'd1,
        KIND_REBOOT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        command;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] byte_index;
        logic [7:0]        payload_byte;
        logic              has_data;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;

endpackage

`default_nettype wire

>>> sv/msp_payload_ram.sv
// ============================================================================
// msp_payload_ram
// Payload byte store: one write port and one registered read port.
// ============================================================================
`default_nettype none

module msp_payload_ram (
    input  wire logic             clk,
    input  wire msp_pkg::ram_ctl_t ctl,
    output logic [7:0]            rdata
);

    logic [7:0] mem [msp_pkg::BUFFER_BYTES];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata <= mem[ctl.raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/msp_parser.sv
// ============================================================================
// msp_parser
// Frame state machine: header match, payload capture, checksum, read-out and idle byte events.
// ============================================================================
`default_nettype none

module msp_parser (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                in_rx_byte,
    input  wire logic                      in_armed,
    input  wire logic [7:0]                reboot_char,
    input  wire logic                      out_free,
    output logic                           res_valid,
    output msp_pkg::result_t               res,
    output msp_pkg::ram_ctl_t              ram_ctl,
    input  wire logic [7:0]                ram_rdata
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DOLLAR  = 7'b0000010,
        ST_M       = 7'b0000100,
        ST_ARROW   = 7'b0001000,
        ST_SIZE    = 7'b0010000,
        ST_PAYLOAD = 7'b0100000,
        ST_READ    = 7'b1000000
    } state_t;

    state_t                             state_reg, state_next;
    logic [msp_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [msp_pkg::LEN_W-1:0]          taken_reg, taken_next;
    logic [7:0]                         xor_reg, xor_next;
    logic [7:0]                         cmd_reg, cmd_next;
    logic [msp_pkg::LEN_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [msp_pkg::ADDR_W-1:0]         pend_idx_reg, pend_idx_next;
    logic                               pend_reg, pend_next;

    logic                               accept;
    logic                               load;
    logic                               rd_en;
    logic                               pend_last;
    logic                               ev_valid;
    msp_pkg::result_t                   ev_res;

    assign in_ready  = (state_reg != ST_READ) && out_free;
    assign accept    = in_valid && in_ready;
    assign load      = (state_reg == ST_READ) && pend_reg && out_free;
    assign rd_en     = (state_reg == ST_READ) && (rd_idx_reg < len_reg) && (!pend_reg || load);
    assign pend_last = ({1'b0, pend_idx_reg} + msp_pkg::LEN_W'(1)) == len_reg;

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        taken_next    = taken_reg;
        xor_next      = xor_reg;
        cmd_next      = cmd_reg;
        rd_idx_next   = rd_idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = pend_reg;
        ev_valid      = 1'b0;
        ev_res        = '0;
        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = taken_reg[msp_pkg::ADDR_W-1:0];
        ram_ctl.wdata = in_rx_byte;
        ram_ctl.re    = rd_en;
        ram_ctl.raddr = rd_idx_reg[msp_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_rx_byte == msp_pkg::CH_DOLLAR)
                    begin
                        state_next = ST_DOLLAR;
                    end
                    else if (!in_armed)
                    begin
                        if (in_rx_byte == msp_pkg::CH_HASH)
                        begin
                            ev_valid    = 1'b1;
                            ev_res.kind = msp_pkg::KIND_CONSOLE;
                            ev_res.last = 1'b1;
                        end
                        else if (in_rx_byte == reboot_char)
                        begin
                            ev_valid    = 1'b1;
                            ev_res.kind = msp_pkg::KIND_REBOOT;
                            ev_res.last = 1'b1;
                        end
                    end
                end
            end
            ST_DOLLAR:
            begin
                if (accept)
                begin
                    state_next = (in_rx_byte == msp_pkg::CH_M) ? ST_M : ST_IDLE;
                end
            end
            ST_M:
            begin
                if (accept)
                begin
                    state_next = (in_rx_byte == msp_pkg::CH_ARROW) ? ST_ARROW : ST_IDLE;
                end
            end
            ST_ARROW:
            begin
                if (accept)
                begin
                    if (in_rx_byte > 8'(msp_pkg::BUFFER_BYTES))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        len_next   = in_rx_byte[msp_pkg::LEN_W-1:0];
                        taken_next = '0;
                        xor_next   = in_rx_byte;
                        state_next = ST_SIZE;
                    end
                end
            end
            ST_SIZE:
            begin
                if (accept)
                begin
                    cmd_next   = in_rx_byte;
                    xor_next   = xor_reg ^ in_rx_byte;
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (accept)
                begin
                    if (taken_reg < len_reg)
                    begin
                        xor_next   = xor_reg ^ in_rx_byte;
                        ram_ctl.we = 1'b1;
                        taken_next = taken_reg + msp_pkg::LEN_W'(1);
                    end
                    else if (xor_reg == in_rx_byte && len_reg != '0)
                    begin
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        if (xor_reg == in_rx_byte)
                        begin
                            ev_valid       = 1'b1;
                            ev_res.kind    = msp_pkg::KIND_FRAME;
                            ev_res.command = cmd_reg;
                            ev_res.last    = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_en)
                begin
                    rd_idx_next   = rd_idx_reg + msp_pkg::LEN_W'(1);
                    pend_idx_next = rd_idx_reg[msp_pkg::ADDR_W-1:0];
                end
                pend_next = rd_en || (pend_reg && !load);
                if (load && pend_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_READ)
        begin
            res_valid        = load;
            res.kind         = msp_pkg::KIND_FRAME;
            res.command      = cmd_reg;
            res.length       = len_reg;
            res.byte_index   = pend_idx_reg;
            res.payload_byte = ram_rdata;
            res.has_data     = 1'b1;
            res.last         = pend_last;
        end
        else
        begin
            res_valid = ev_valid;
            res       = ev_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            taken_reg    <= '0;
            xor_reg      <= '0;
            cmd_reg      <= '0;
            rd_idx_reg   <= '0;
            pend_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            taken_reg    <= taken_next;
            xor_reg      <= xor_next;
            cmd_reg      <= cmd_next;
            rd_idx_reg   <= rd_idx_next;
            pend_idx_reg <= pend_idx_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/msp_out_stage.sv
// ============================================================================
// msp_out_stage
// Output register that holds one result beat until the sink takes it.
// ============================================================================
`default_nettype none

module msp_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire msp_pkg::result_t res,
    output logic                  out_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output msp_pkg::result_t      out_res
);

    logic             valid_reg;
    msp_pkg::result_t data_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> sv/msp_frame_receiver.sv
// ============================================================================
// msp_frame_receiver
// Request frame receiver: parses '$' 'M' '<' frames and replays good ones.
// ============================================================================
//
//  Channel   Dir   Carries
//  s_axis    in    one received byte and the armed flag per beat
//  m_axis    out   frame items, console and reboot requests
//  APB       in    reboot_char register at byte address 0
//
//  While parsing, one byte is taken per cycle when the output register is free.
//  A good frame of N > 0 payload bytes is read from the payload RAM, one read
//  per cycle while the output register is free, giving N result beats; input
//  is held off during this read-out. Reset is asynchronous and needs no
//  clearing pass; the payload RAM is only read where the same frame wrote it.
// ============================================================================
`default_nettype none

module msp_frame_receiver (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [15:0]                  s_axis_tdata,  // rx_byte, armed
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // command, length, byte_index, payload_byte, has_data
    output logic [31:0]                       m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,  // kind
    output logic                              m_axis_tlast,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [msp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [7:0]        reboot_char_reg;
    logic              out_free;
    logic              res_valid;
    msp_pkg::result_t  res;
    msp_pkg::result_t  out_res;
    msp_pkg::ram_ctl_t ram_ctl;
    logic [7:0]        ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == msp_pkg::REG_REBOOT_CHAR) ? {24'd0, reboot_char_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reboot_char_reg <= msp_pkg::REBOOT_CHAR_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == msp_pkg::REG_REBOOT_CHAR)
        begin
            reboot_char_reg <= pwdata[7:0];
        end
    end

    msp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_rx_byte  (s_axis_tdata[7:0]),
        .in_armed    (s_axis_tdata[8]),
        .reboot_char (reboot_char_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_ctl     (ram_ctl),
        .ram_rdata   (ram_rdata)
    );

    msp_payload_ram u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .rdata (ram_rdata)
    );

    msp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.has_data, out_res.payload_byte,
                           out_res.byte_index, out_res.length, out_res.command};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

>>> sv/msp_frame_receiver_chk.sv
// ============================================================================
// msp_frame_receiver_chk
// Port-level checks for the request frame receiver, bound to the top level.
// ============================================================================
`default_nettype none

module msp_frame_receiver_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [31:0]                  m_axis_tdata,
    input wire logic [1:0]                   m_axis_tuser,
    input wire logic                         m_axis_tlast
);

    // A stalled beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

    // Requests are single beats with no payload fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != msp_pkg::KIND_FRAME |->
            m_axis_tlast && m_axis_tdata == 32'd0
            && (m_axis_tuser == msp_pkg::KIND_CONSOLE || m_axis_tuser == msp_pkg::KIND_REBOOT))
    else $error("malformed request beat");

    // A frame beat without data is the lone beat of an empty frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == msp_pkg::KIND_FRAME && !m_axis_tdata[29] |->
            m_axis_tlast && m_axis_tdata[28:8] == 21'd0)
    else $error("empty frame beat carries fields");

    // Within a run the byte index steps by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == msp_pkg::KIND_FRAME
            && !m_axis_tlast ##1 m_axis_tvalid |->
            m_axis_tdata[20:15] == $past(m_axis_tdata[20:15]) + 6'd1
            && m_axis_tdata[7:0] == $past(m_axis_tdata[7:0]))
    else $error("frame run out of order");

endmodule

bind msp_frame_receiver msp_frame_receiver_chk u_chk (.*);

`default_nettype wire

>>> dv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench for the serial request frame receiver.
// ============================================================================
//
//  Bytes go in on the slave stream, and a scoreboard class tracks the parser
//  state, the checksum and the payload buffer. It predicts every frame item
//  and every console or reboot request, and checks each master stream beat
//  against the oldest prediction. A short directed part covers empty, single
//  byte and full frames, bad checksums, oversize lengths, broken headers and
//  the idle byte events. Random frames and noise follow, under several reboot
//  characters, with random gaps and output stalls.
// ============================================================================
`default_nettype none

module tb_top;

    typedef enum int {
        PS_IDLE,
        PS_DOLLAR,
        PS_M,
        PS_ARROW,
        PS_CMD,
        PS_PAYLOAD
    } parse_t;

    class frame_scoreboard;
        parse_t             pstate;
        logic [7:0]         reboot_char;
        logic [6:0]         frame_len;
        logic [6:0]         taken;
        logic [7:0]         xor_acc;
        logic [7:0]         cmd;
        logic [7:0]         store [msp_pkg::BUFFER_BYTES];
        msp_pkg::result_t   pending [$];
        int                 errors;
        int                 checked;
        int                 frames;

        function new();
            pstate      = PS_IDLE;
            reboot_char = msp_pkg::REBOOT_CHAR_RESET;
            frame_len   = '0;
            taken       = '0;
            xor_acc     = '0;
            cmd         = '0;
            errors      = 0;
            checked     = 0;
            frames      = 0;
        endfunction

        function void set_reboot_char(logic [7:0] v);
            reboot_char = v;
        endfunction

        function void push_event(msp_pkg::kind_t k);
            msp_pkg::result_t r;
            r      = '0;
            r.kind = k;
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        function void note_input(logic [7:0] c, logic armed);
            msp_pkg::result_t r;
            int               i;
            case (pstate)
                PS_IDLE:
                begin
                    if (c == msp_pkg::CH_DOLLAR)
                        pstate = PS_DOLLAR;
                    else if (!armed && c == msp_pkg::CH_HASH)
                        push_event(msp_pkg::KIND_CONSOLE);
                    else if (!armed && c == reboot_char)
                        push_event(msp_pkg::KIND_REBOOT);
                end
                PS_DOLLAR:
                    pstate = (c == msp_pkg::CH_M) ? PS_M : PS_IDLE;
                PS_M:
                    pstate = (c == msp_pkg::CH_ARROW) ? PS_ARROW : PS_IDLE;
                PS_ARROW:
                begin
                    if (c > msp_pkg::BUFFER_BYTES)
                    begin
                        pstate = PS_IDLE;
                    end
                    else
                    begin
                        frame_len = c[6:0];
                        taken     = '0;
                        xor_acc   = c;
                        pstate    = PS_CMD;
                    end
                end
                PS_CMD:
                begin
                    cmd     = c;
                    xor_acc = xor_acc ^ c;
                    pstate  = PS_PAYLOAD;
                end
                PS_PAYLOAD:
                begin
                    if (taken < frame_len)
                    begin
                        xor_acc = xor_acc ^ c;
                        store[taken[msp_pkg::ADDR_W-1:0]] = c;
                        taken   = taken + 7'd1;
                    end
                    else
                    begin
                        if (xor_acc == c)
                        begin
                            frames++;
                            if (frame_len == 0)
                            begin
                                r         = '0;
                                r.kind    = msp_pkg::KIND_FRAME;
                                r.command = cmd;
                                r.last    = 1'b1;
                                pending.push_back(r);
                            end
                            else
                            begin
                                for (i = 0; i < frame_len; i++)
                                begin
                                    r              = '0;
                                    r.kind         = msp_pkg::KIND_FRAME;
                                    r.command      = cmd;
                                    r.length       = frame_len;
                                    r.byte_index   = i[msp_pkg::ADDR_W-1:0];
                                    r.payload_byte = store[i[msp_pkg::ADDR_W-1:0]];
                                    r.has_data     = 1'b1;
                                    r.last         = (i + 1 == frame_len);
                                    pending.push_back(r);
                                end
                            end
                        end
                        pstate = PS_IDLE;
                    end
                end
                default:
                    pstate = PS_IDLE;
            endcase
        endfunction

        function void check_field(string name, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                errors++;
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
            end
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] user, logic lastb);
            msp_pkg::result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $error("unexpected result beat: tdata 0x%08h tuser %0d", data, user);
                return;
            end
            e = pending.pop_front();
            check_field("kind",         32'(e.kind),         32'(user));
            check_field("command",      32'(e.command),      32'(data[7:0]));
            check_field("length",       32'(e.length),       32'(data[14:8]));
            check_field("byte_index",   32'(e.byte_index),   32'(data[20:15]));
            check_field("payload_byte", 32'(e.payload_byte), 32'(data[28:21]));
            check_field("has_data",     32'(e.has_data),     32'(data[29]));
            check_field("last",         32'(e.last),         32'(lastb));
        endfunction
    endclass

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    wire logic                    s_axis_tready;
    logic [15:0]                  s_axis_tdata  = '0;   // rx_byte [7:0], armed [8]
    wire logic                    m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    wire logic [31:0]             m_axis_tdata;         // command, length, byte_index,
                                                        // payload_byte, has_data
    wire logic [1:0]              m_axis_tuser;         // kind
    wire logic                    m_axis_tlast;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [msp_pkg::PADDR_W-1:0]  paddr         = '0;
    logic [31:0]                  pwdata        = '0;
    wire logic [31:0]             prdata;
    wire logic                    pready;

    frame_scoreboard     sb;
    bit                  calm       = 1'b0;
    int                  stall_left = 0;
    int                  beats_sent = 0;
    int                  settings   = 1;

    msp_frame_receiver uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_byte(logic [7:0] b, logic armed);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, armed, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(b, armed);
        beats_sent++;
    endtask

    task automatic send_frame(logic [7:0] len, logic [7:0] command, bit corrupt);
        logic [7:0] chk;
        logic [7:0] b;
        int         i;
        send_byte(msp_pkg::CH_DOLLAR, 1'($urandom_range(0, 1)));
        send_byte(msp_pkg::CH_M, 1'($urandom_range(0, 1)));
        send_byte(msp_pkg::CH_ARROW, 1'($urandom_range(0, 1)));
        send_byte(len, 1'($urandom_range(0, 1)));
        send_byte(command, 1'($urandom_range(0, 1)));
        chk = len ^ command;
        for (i = 0; i < len; i++)
        begin
            b   = 8'($urandom_range(0, 255));
            chk = chk ^ b;
            send_byte(b, 1'($urandom_range(0, 1)));
        end
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reboot_char(logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= msp_pkg::REG_REBOOT_CHAR;
        pwdata  <= {24'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reboot_char(v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    task automatic run_random(int count);
        int stop;
        int n;
        int sel;
        stop = beats_sent + count;
        while (beats_sent < stop)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 6)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
                                                : $urandom_range(0, 8);
                send_frame(8'(n), 8'($urandom_range(0, 255)), sel == 6);
            end
            else if (sel == 7)
            begin
                send_byte(msp_pkg::CH_DOLLAR, 1'($urandom_range(0, 1)));
                case ($urandom_range(0, 3))
                    0: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    1:
                    begin
                        send_byte(msp_pkg::CH_M, 1'($urandom_range(0, 1)));
                        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    end
                    2:
                    begin
                        send_byte(msp_pkg::CH_M, 1'($urandom_range(0, 1)));
                        send_byte(msp_pkg::CH_ARROW, 1'($urandom_range(0, 1)));
                        send_byte(8'($urandom_range(65, 255)), 1'($urandom_range(0, 1)));
                    end
                    default: send_byte(msp_pkg::CH_DOLLAR, 1'($urandom_range(0, 1)));
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0: send_byte(msp_pkg::CH_HASH, 1'($urandom_range(0, 1)));
                        1: send_byte(sb.reboot_char, 1'($urandom_range(0, 1)));
                        default:
                            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    endcase
                end
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("** msp_frame_receiver: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Idle byte events under the reset reboot character.
        send_byte(msp_pkg::REBOOT_CHAR_RESET, 1'b0);
        send_byte(msp_pkg::REBOOT_CHAR_RESET, 1'b1);
        send_byte(msp_pkg::CH_HASH, 1'b0);
        send_byte(msp_pkg::CH_HASH, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Frames: empty, single byte, full buffer, and a bad checksum.
        send_frame(8'd0, 8'h00, 1'b0);
        send_frame(8'd1, 8'hFF, 1'b0);
        send_frame(8'd64, 8'hA5, 1'b0);
        send_frame(8'd2, 8'h5A, 1'b1);

        // Broken headers and oversize lengths.
        send_byte(msp_pkg::CH_DOLLAR, 1'b0);
        send_byte(msp_pkg::CH_DOLLAR, 1'b0);
        send_byte(msp_pkg::CH_M, 1'b0);
        send_byte(msp_pkg::CH_DOLLAR, 1'b0);
        send_byte(msp_pkg::CH_M, 1'b0);
        send_byte(msp_pkg::CH_HASH, 1'b0);
        send_byte(msp_pkg::CH_DOLLAR, 1'b0);
        send_byte(msp_pkg::CH_M, 1'b0);
        send_byte(msp_pkg::CH_ARROW, 1'b0);
        send_byte(8'd65, 1'b0);
        send_byte(msp_pkg::CH_DOLLAR, 1'b0);
        send_byte(msp_pkg::CH_M, 1'b0);
        send_byte(msp_pkg::CH_ARROW, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(msp_pkg::CH_HASH, 1'b0);
        drain();

        run_random(60);
        drain();
        write_reboot_char(8'h00);
        run_random(60);
        drain();
        write_reboot_char(8'hFF);
        run_random(60);
        drain();
        write_reboot_char(msp_pkg::CH_DOLLAR);
        send_byte(msp_pkg::CH_DOLLAR, 1'b0);
        send_byte(msp_pkg::CH_HASH, 1'b0);
        run_random(60);
        drain();
        write_reboot_char(msp_pkg::CH_HASH);
        send_byte(msp_pkg::CH_HASH, 1'b0);
        run_random(15);
        drain();
        write_reboot_char(8'($urandom_range(0, 255)));
        calm = 1'b1;
        run_random(50);
        drain();

        if (sb.pending.size() != 0)
        begin
            sb.errors++;
            $error("%0d expected result beats never arrived", sb.pending.size());
        end
        $display("Sent %0d input beats under %0d reboot characters.", beats_sent, settings);
        $display("Checked %0d result beats from %0d good frames.", sb.checked, sb.frames);
        if (sb.errors == 0)
            $display("** msp_frame_receiver: PASSED **");
        else
            $display("** msp_frame_receiver: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
